FILE: hw/rtl/segment_cylinder_block_test_defines.svh
// assertion macros for the segment versus cylinder blocking test
// used by segment_cylinder_block_test; needs clk_i and rst_ni in scope
`ifndef SEGMENT_CYLINDER_BLOCK_TEST_DEFINES_SVH
`define SEGMENT_CYLINDER_BLOCK_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define SCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define SCB_ASSERT(lbl, prop, msg)
`define SCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/scb_pkg.sv
// shared widths and constants of the segment versus cylinder test
// no dependencies
package scb_pkg;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned VertW     = 34;
  localparam int unsigned WideW     = 64;
  localparam int unsigned ProdW     = 2 * WideW;
  localparam int unsigned RootW     = 63;
  localparam int unsigned DiscW     = 2 * RootW;
  localparam int unsigned MulLat    = 4;
  localparam int unsigned NumFields = 11;
  localparam int unsigned InDataW   = NumFields * CoordW;
  localparam int unsigned OutDataW  = 8;
  localparam logic signed [WideW-1:0] SqEps = 64'sd1;
endpackage

FILE: hw/rtl/scb_delay.sv
// fixed-depth shift line with stall enable
// no dependencies
module scb_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);
  logic [Width-1:0] pipe_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[Depth-1];
endmodule

FILE: hw/rtl/scb_mul.sv
// four-stage signed 64 by 64 multiplier from 32 by 32 partial products
// depends on scb_pkg
module scb_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [scb_pkg::WideW-1:0]    a_i,
  input  logic signed [scb_pkg::WideW-1:0]    b_i,
  output logic signed [scb_pkg::ProdW-1:0]    p_o
);
  localparam int unsigned W = scb_pkg::WideW;
  localparam int unsigned H = W / 2;

  logic [W-1:0] ma_q, mb_q, ma_d, mb_d;
  logic         neg1_q, neg2_q, neg3_q;
  logic [W-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [2*W-1:0] sum_q, sum_d;
  logic [2*W-1:0] p_q;

  assign ma_d = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mb_d = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  assign sum_d = {{W{1'b0}}, pp00_q} + {{H{1'b0}}, pp01_q, {H{1'b0}}}
               + {{H{1'b0}}, pp10_q, {H{1'b0}}} + {pp11_q, {W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      neg1_q <= a_i[W-1] ^ b_i[W-1];
      pp00_q <= W'(ma_q[H-1:0]) * W'(mb_q[H-1:0]);
      pp01_q <= W'(ma_q[H-1:0]) * W'(mb_q[W-1:H]);
      pp10_q <= W'(ma_q[W-1:H]) * W'(mb_q[H-1:0]);
      pp11_q <= W'(ma_q[W-1:H]) * W'(mb_q[W-1:H]);
      neg2_q <= neg1_q;
      sum_q  <= sum_d;
      neg3_q <= neg2_q;
      p_q    <= neg3_q ? (~sum_q + (2*W)'(1)) : sum_q;
    end
  end

  assign p_o = $signed(p_q);
endmodule

FILE: hw/rtl/scb_sqrt.sv
// pipelined floor square root, one result bit per stage
// depends on scb_pkg
module scb_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [scb_pkg::DiscW-1:0]     d_i,
  output logic [scb_pkg::RootW-1:0]     root_o
);
  localparam int unsigned RW = scb_pkg::RootW;
  localparam int unsigned DW = scb_pkg::DiscW;

  logic [DW-1:0] d_q  [RW];
  logic [RW-1:0] s_q  [RW];
  logic [DW-1:0] s2_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic [DW-1:0] din, s2in;
    logic [RW-1:0] sin;
    logic [DW:0]   cand2;
    logic          take;

    if (k == 0) begin : g_first
      assign din  = d_i;
      assign sin  = '0;
      assign s2in = '0;
    end else begin : g_next
      assign din  = d_q[k-1];
      assign sin  = s_q[k-1];
      assign s2in = s2_q[k-1];
    end

    assign cand2 = {1'b0, s2in} + ((DW+1)'(sin) << (B + 1)) + ((DW+1)'(1) << (2 * B));
    assign take  = cand2 <= {1'b0, din};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]  <= din;
        s_q[k]  <= take ? (sin | (RW'(1) << B)) : sin;
        s2_q[k] <= take ? cand2[DW-1:0] : s2in;
      end
    end
  end

  assign root_o = s_q[RW-1];
endmodule

FILE: hw/rtl/segment_cylinder_block_test.sv
// top level: segment versus upright capped cylinder blocking test
// depends on scb_pkg, scb_delay, scb_mul, scb_sqrt and the defines header
//
//   channel   dir  width  beat contents (low bit first)
//   s_axis    in   352    start_x y z, end_x y z, center_x z, radius, base_y, cyl_height
//   m_axis    out  8      blocked, invalid_cylinder, zero fill
//
// one beat per cycle while the output is not stalled; each beat passes from input to result
// through the 63-stage square root and two 4-stage multipliers
// reset clears all valid bits; no clearing pass
// a stalled output freezes the whole pipeline, nothing lost or repeated
`include "segment_cylinder_block_test_defines.svh"
module segment_cylinder_block_test (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_z,
  // radius, base_y, cyl_height
  input  logic [scb_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // blocked, invalid_cylinder, zero fill
  output logic [scb_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  localparam int unsigned CW = scb_pkg::CoordW;
  localparam int unsigned VW = scb_pkg::VertW;
  localparam int unsigned WW = scb_pkg::WideW;
  localparam int unsigned PW = scb_pkg::ProdW;
  localparam int unsigned RW = scb_pkg::RootW;
  localparam int unsigned DW = scb_pkg::DiscW;
  localparam int unsigned ML = scb_pkg::MulLat;
  localparam int unsigned DiscStage = 4 + ML + 1;
  localparam int unsigned RootStage = DiscStage + RW;
  localparam int unsigned FinStage  = RootStage + ML;
  localparam int unsigned OutStage  = FinStage + 1;

  function automatic logic signed [CW-1:0] sat_diff(input logic signed [CW:0] v);
    logic signed [CW:0] lim;
    lim = (CW+1)'({1'b0, {(CW-1){1'b1}}});
    if (v > lim) return {1'b0, {(CW-1){1'b1}}};
    else if (v < -lim) return {1'b1, {(CW-2){1'b0}}, 1'b1};
    else return v[CW-1:0];
  endfunction

  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: differences and vertical slab
  logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, cx, cz, rad, base, hgt;
  assign sx   = s_axis_tdata_i[0*CW +: CW];
  assign sy   = s_axis_tdata_i[1*CW +: CW];
  assign sz   = s_axis_tdata_i[2*CW +: CW];
  assign ex   = s_axis_tdata_i[3*CW +: CW];
  assign ey   = s_axis_tdata_i[4*CW +: CW];
  assign ez   = s_axis_tdata_i[5*CW +: CW];
  assign cx   = s_axis_tdata_i[6*CW +: CW];
  assign cz   = s_axis_tdata_i[7*CW +: CW];
  assign rad  = s_axis_tdata_i[8*CW +: CW];
  assign base = s_axis_tdata_i[9*CW +: CW];
  assign hgt  = s_axis_tdata_i[10*CW +: CW];

  logic signed [VW-1:0] sy_w, base_w, dy, top, av_d, cv_d, m_d;
  logic                 vmiss_d, c34_d, inv_d;

  always_comb begin
    sy_w    = VW'(sy);
    base_w  = VW'(base);
    dy      = VW'(ey) - sy_w;
    top     = base_w + VW'(hgt);
    vmiss_d = 1'b0;
    if (dy == '0) begin
      av_d    = '0;
      cv_d    = VW'(1);
      m_d     = VW'(1);
      vmiss_d = (sy_w < base_w) || (sy_w > top);
    end else if (dy > 0) begin
      av_d = base_w - sy_w;
      cv_d = top - sy_w;
      m_d  = dy;
    end else begin
      av_d = sy_w - top;
      cv_d = sy_w - base_w;
      m_d  = -dy;
    end
    c34_d = (av_d <= m_d) && (cv_d >= 0);
    inv_d = (rad <= 0) || (hgt <= 0);
  end

  logic signed [CW-1:0] s1_dx_q, s1_dz_q, s1_hx_q, s1_hz_q, s1_r_q;
  logic signed [VW-1:0] s1_av_q, s1_cv_q, s1_m_q;
  logic                 s1_inv_q, s1_vmiss_q, s1_c34_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q    <= sat_diff((CW+1)'(ex) - (CW+1)'(sx));
      s1_dz_q    <= sat_diff((CW+1)'(ez) - (CW+1)'(sz));
      s1_hx_q    <= sat_diff((CW+1)'(sx) - (CW+1)'(cx));
      s1_hz_q    <= sat_diff((CW+1)'(sz) - (CW+1)'(cz));
      s1_r_q     <= rad;
      s1_av_q    <= av_d;
      s1_cv_q    <= cv_d;
      s1_m_q     <= m_d;
      s1_inv_q   <= inv_d;
      s1_vmiss_q <= vmiss_d;
      s1_c34_q   <= c34_d;
    end
  end

  // stage 2: squares and cross terms
  logic signed [WW-1:0] s2_dxx_q, s2_dzz_q, s2_hxx_q, s2_hzz_q, s2_hdx_q, s2_hdz_q, s2_r2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dxx_q <= WW'(s1_dx_q) * WW'(s1_dx_q);
      s2_dzz_q <= WW'(s1_dz_q) * WW'(s1_dz_q);
      s2_hxx_q <= WW'(s1_hx_q) * WW'(s1_hx_q);
      s2_hzz_q <= WW'(s1_hz_q) * WW'(s1_hz_q);
      s2_hdx_q <= WW'(s1_hx_q) * WW'(s1_dx_q);
      s2_hdz_q <= WW'(s1_hz_q) * WW'(s1_dz_q);
      s2_r2_q  <= WW'(s1_r_q) * WW'(s1_r_q);
    end
  end

  // stage 3: sums
  logic signed [WW-1:0] s3_len2_q, s3_hh_q, s3_b_q, s3_r2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_len2_q <= s2_dxx_q + s2_dzz_q;
      s3_hh_q   <= s2_hxx_q + s2_hzz_q;
      s3_b_q    <= s2_hdx_q + s2_hdz_q;
      s3_r2_q   <= s2_r2_q;
    end
  end

  // stage 4: quadratic coefficients
  logic signed [WW-1:0] s4_nb_q, s4_c_q, s4_len2_q;
  logic                 s4_short_q, s4_smiss_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_nb_q    <= -s3_b_q;
      s4_c_q     <= s3_hh_q - s3_r2_q;
      s4_len2_q  <= s3_len2_q;
      s4_short_q <= s3_len2_q <= scb_pkg::SqEps;
      s4_smiss_q <= s3_hh_q > s3_r2_q;
    end
  end

  // discriminant products
  logic signed [PW-1:0] bb, lc;
  scb_mul u_mul_bb (.clk_i, .en_i(en), .a_i(s4_nb_q), .b_i(s4_nb_q), .p_o(bb));
  scb_mul u_mul_lc (.clk_i, .en_i(en), .a_i(s4_len2_q), .b_i(s4_c_q), .p_o(lc));

  logic signed [PW-1:0] disc;
  logic [DW-1:0]        disc_q;
  logic                 disc_neg_q;
  assign disc = bb - lc;
  always_ff @(posedge clk_i) begin
    if (en) begin
      disc_neg_q <= disc[PW-1];
      disc_q     <= (disc[PW-1:DW] != '0) ? {DW{1'b1}} : disc[DW-1:0];
    end
  end

  logic [RW-1:0] root;
  scb_sqrt u_sqrt (.clk_i, .en_i(en), .d_i(disc_q), .root_o(root));

  // side data carried to the root stage; the flags go on to the final compare
  logic [3*VW-1:0] vert_dly;
  logic [2*WW+1:0] hor_dly;
  logic            neg_dly;
  logic [2:0]      flag_dly;

  scb_delay #(.Width(3*VW), .Depth(RootStage - 1)) u_dly_vert (
    .clk_i, .rst_ni, .en_i(en), .d_i({s1_av_q, s1_cv_q, s1_m_q}), .q_o(vert_dly));
  scb_delay #(.Width(3), .Depth(FinStage - 1)) u_dly_flag (
    .clk_i, .rst_ni, .en_i(en), .d_i({s1_inv_q, s1_vmiss_q, s1_c34_q}), .q_o(flag_dly));
  scb_delay #(.Width(2*WW+2), .Depth(RootStage - 4)) u_dly_hor (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({s4_nb_q, s4_len2_q, s4_short_q, s4_smiss_q}), .q_o(hor_dly));
  scb_delay #(.Width(1), .Depth(RootStage - DiscStage)) u_dly_neg (
    .clk_i, .rst_ni, .en_i(en), .d_i(disc_neg_q), .q_o(neg_dly));

  // root stage: interval ends
  logic signed [VW-1:0] r_av, r_cv, r_m;
  logic signed [WW-1:0] r_nb, r_len2, nb_f, s_f, den_f;
  logic                 r_short, r_smiss, hmiss, c1, c2;

  always_comb begin
    r_av    = $signed(vert_dly[2*VW +: VW]);
    r_cv    = $signed(vert_dly[VW +: VW]);
    r_m     = $signed(vert_dly[0 +: VW]);
    r_nb    = $signed(hor_dly[WW+2 +: WW]);
    r_len2  = $signed(hor_dly[2 +: WW]);
    r_short = hor_dly[1];
    r_smiss = hor_dly[0];
    nb_f    = r_short ? WW'(1) : r_nb;
    s_f     = r_short ? WW'(1) : $signed({1'b0, root});
    den_f   = r_short ? WW'(2) : r_len2;
    hmiss   = r_short ? r_smiss : neg_dly;
    c1      = ((WW+2)'(nb_f) - (WW+2)'(s_f)) <= (WW+2)'(den_f);
    c2      = ((WW+2)'(nb_f) + (WW+2)'(s_f)) >= 0;
  end

  logic [2:0] hfin_dly;
  scb_delay #(.Width(3), .Depth(ML)) u_dly_hfin (
    .clk_i, .rst_ni, .en_i(en), .d_i({hmiss, c1, c2}), .q_o(hfin_dly));

  logic signed [PW-1:0] bm, sm, cvden, avden;
  scb_mul u_mul_bm (.clk_i, .en_i(en), .a_i(nb_f), .b_i(WW'(r_m)), .p_o(bm));
  scb_mul u_mul_sm (.clk_i, .en_i(en), .a_i(s_f), .b_i(WW'(r_m)), .p_o(sm));
  scb_mul u_mul_cv (.clk_i, .en_i(en), .a_i(WW'(r_cv)), .b_i(den_f), .p_o(cvden));
  scb_mul u_mul_av (.clk_i, .en_i(en), .a_i(WW'(r_av)), .b_i(den_f), .p_o(avden));

  // final compare and output register
  logic hit, blocked_d;
  logic [1:0] out_q;
  always_comb begin
    hit = !flag_dly[1] && !hfin_dly[2] && hfin_dly[1] && hfin_dly[0] && flag_dly[0]
       && ((bm - sm) <= cvden) && (avden <= (bm + sm));
    blocked_d = flag_dly[2] || hit;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {flag_dly[2], blocked_d};
  end

  scb_delay #(.Width(1), .Depth(OutStage)) u_dly_valid (
    .clk_i, .rst_ni, .en_i(en), .d_i(s_axis_tvalid_i), .q_o(m_axis_tvalid_o));

  assign m_axis_tdata_o = {(scb_pkg::OutDataW-2)'(0), out_q};

  `SCB_ASSERT(a_invalid_blocks, m_axis_tvalid_o && m_axis_tdata_o[1] |-> m_axis_tdata_o[0], "invalid cylinder result not blocked")
  `SCB_ASSERT(a_stall_source, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output backpressure")
  `SCB_ASSERT_NEXT(a_stall_freeze, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "pending result lost during stall")
endmodule

FILE: bench/scb_checker.sv
// checker for the segment versus cylinder blocking test: watches both stream channels,
// predicts each result from the accepted input beat and compares it; uses scb_pkg
module scb_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [scb_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [scb_pkg::OutDataW-1:0] m_axis_tdata_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] cyl_height;
    logic signed [31:0] base_y;
    logic signed [31:0] radius;
    logic signed [31:0] center_z;
    logic signed [31:0] center_x;
    logic signed [31:0] end_z;
    logic signed [31:0] end_y;
    logic signed [31:0] end_x;
    logic signed [31:0] start_z;
    logic signed [31:0] start_y;
    logic signed [31:0] start_x;
  } seg_cyl_t;

  typedef logic signed [127:0] wide_t;

  // {invalid_cylinder, blocked}
  logic [1:0] verdict_q[$];

  function automatic wide_t clamp_diff(wide_t v);
    wide_t lim;
    lim = 128'sd2147483647;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [1:0] blocking_of(seg_cyl_t p);
    wide_t sx, sy, sz, ex, ey, ez, cx, cz, r, base, h;
    wide_t r2, dx, dz, hx, hz, len2, hh, b, c, disc, root, cand, nb, den;
    wide_t dy, top, av, cv, m, bm, sm;
    logic hit;
    sx = p.start_x; sy = p.start_y; sz = p.start_z;
    ex = p.end_x; ey = p.end_y; ez = p.end_z;
    cx = p.center_x; cz = p.center_z;
    r = p.radius; base = p.base_y; h = p.cyl_height;
    if (r <= 0 || h <= 0) return 2'b11;
    r2 = r * r;
    dx = clamp_diff(ex - sx);
    dz = clamp_diff(ez - sz);
    hx = clamp_diff(sx - cx);
    hz = clamp_diff(sz - cz);
    len2 = dx * dx + dz * dz;
    hh = hx * hx + hz * hz;
    // almost no horizontal travel: point in circle
    if (len2 <= wide_t'(scb_pkg::SqEps)) begin
      if (hh > r2) return 2'b00;
      nb = 1; root = 1; den = 2;
    end else begin
      b = hx * dx + hz * dz;
      c = hh - r2;
      disc = b * b - len2 * c;
      if (disc < 0) return 2'b00;
      root = 0;
      for (int k = 62; k >= 0; k--) begin
        cand = root | (128'sd1 << k);
        if (cand * cand <= disc) root = cand;
      end
      nb = -b;
      den = len2;
    end
    dy = ey - sy;
    top = base + h;
    if (dy == 0) begin
      if (sy < base || sy > top) return 2'b00;
      av = 0; cv = 1; m = 1;
    end else if (dy > 0) begin
      av = base - sy; cv = top - sy; m = dy;
    end else begin
      av = sy - top; cv = sy - base; m = -dy;
    end
    bm = nb * m;
    sm = root * m;
    hit = (nb - root <= den) && (nb + root >= 0) && (av <= m) && (cv >= 0)
       && (bm - sm <= cv * den) && (av * den <= bm + sm);
    return {1'b0, hit};
  endfunction

  assign pending_o = verdict_q.size();

  initial errors_o = 0;

  always @(posedge clk_i) begin
    logic [1:0] want;
    int nerr;
    nerr = 0;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        verdict_q.push_back(blocking_of(seg_cyl_t'(s_axis_tdata_i)));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no pending item: %h", m_axis_tdata_i);
          nerr++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata_i[0] !== want[0]) begin
            $error("blocked: expected %0d, got %0d", want[0], m_axis_tdata_i[0]);
            nerr++;
          end
          if (m_axis_tdata_i[1] !== want[1]) begin
            $error("invalid_cylinder: expected %0d, got %0d", want[1], m_axis_tdata_i[1]);
            nerr++;
          end
          if (m_axis_tdata_i[7:2] !== 6'd0) begin
            $error("zero fill: expected 0, got %0d", m_axis_tdata_i[7:2]);
            nerr++;
          end
        end
      end
      if (nerr != 0) errors_o <= errors_o + nerr;
    end
  end
endmodule

FILE: bench/tb.sv
// top of the segment versus cylinder test bench: clock, reset, directed and random
// segment/cylinder beats, output back-pressure and the verdict; uses scb_checker, scb_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int One = 65536;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [scb_pkg::InDataW-1:0]  s_data = '0;
  logic                         m_valid;
  logic                         m_ready = 1'b0;
  logic [scb_pkg::OutDataW-1:0] m_data;
  int                           errors;
  int                           pending;

  always #2 clk_i = ~clk_i;

  segment_cylinder_block_test DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  scb_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  function automatic logic [scb_pkg::InDataW-1:0] pack_pair(
      int sx, int sy, int sz, int ex, int ey, int ez,
      int cx, int cz, int r, int base, int h);
    return {h, base, r, cz, cx, ez, ey, ex, sz, sy, sx};
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [scb_pkg::InDataW-1:0] random_pair();
    int mode, cx, cz, r, base, h, sx, sy, sz, ex, ey, ez;
    logic [scb_pkg::InDataW-1:0] raw;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      for (int k = 0; k < scb_pkg::NumFields; k++) raw[k*32 +: 32] = $urandom;
      return raw;
    end
    cx = spread(1 << 23);
    cz = spread(1 << 23);
    r = $urandom_range(1, ($urandom_range(0, 1) != 0) ? (1 << 22) : 64);
    base = spread(1 << 23);
    h = $urandom_range(1, 1 << 22);
    sx = cx + spread(3 * r);
    sz = cz + spread(3 * r);
    ex = cx + spread(3 * r);
    ez = cz + spread(3 * r);
    sy = base + spread(2 * h);
    ey = base + spread(2 * h);
    if (mode < 16) begin
      if ($urandom_range(0, 1) != 0) r = -int'($urandom_range(0, 1 << 22));
      else h = -int'($urandom_range(0, 1 << 22));
    end else if (mode < 24) begin
      ex = sx + spread(1);
      ez = sz + int'($urandom_range(0, 1)) * spread(1);
    end else if (mode < 32) begin
      ey = sy;
    end else if (mode < 36) begin
      sx = $urandom;
      ex = $urandom;
    end
    return pack_pair(sx, sy, sz, ex, ey, ez, cx, cz, r, base, h);
  endfunction

  task automatic send_beat(input logic [scb_pkg::InDataW-1:0] d, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 7) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= d;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // output back-pressure: one long hold-off, one stretch with no stalls
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 800 && cyc < 1100) m_ready <= 1'b0;
      else if (cyc >= 1400 && cyc < 1800) m_ready <= 1'b1;
      else m_ready <= ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int maxi, mini;
    maxi = 32'h7fffffff;
    mini = 32'h80000000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // invalid cylinders
    send_beat(pack_pair(0, 0, 0, One, 0, 0, 0, 0, 0, 0, One), 1'b1);
    send_beat(pack_pair(0, 0, 0, One, 0, 0, 0, 0, -1, 0, One), 1'b1);
    send_beat(pack_pair(0, 0, 0, One, 0, 0, 0, 0, One, 0, 0), 1'b1);
    send_beat(pack_pair(0, 0, 0, One, 0, 0, 0, 0, mini, 0, mini), 1'b1);
    // field extremes, saturated differences
    send_beat(pack_pair(maxi, maxi, maxi, maxi, maxi, maxi, maxi, maxi, maxi, maxi, maxi), 1'b1);
    send_beat(pack_pair(mini, mini, mini, mini, mini, mini, mini, mini, maxi, mini, maxi), 1'b1);
    send_beat(pack_pair(maxi, 0, mini, mini, 0, maxi, 0, 0, maxi, mini, maxi), 1'b1);
    send_beat(pack_pair(maxi, 0, 0, mini, 0, 0, 0, 0, One, 0, One), 1'b1);
    // tangent and just outside
    send_beat(pack_pair(-2 * One, One / 2, One, 2 * One, One / 2, One, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(-2 * One, One / 2, One + 1, 2 * One, One / 2, One + 1,
                        0, 0, One, 0, One), 1'b1);
    // almost no horizontal travel, inside and outside
    send_beat(pack_pair(10, -One, 5, 11, 2 * One, 5, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(One + 1, -One, 0, One + 1, 2 * One, 0, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(0, 5 * One, 0, 0, 5 * One, 0, 0, 0, One, 0, One), 1'b1);
    // flat segment above top, on top, on base
    send_beat(pack_pair(-2 * One, 2 * One, 0, 2 * One, 2 * One, 0, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(-2 * One, One, 0, 2 * One, One, 0, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(-2 * One, 0, 0, 2 * One, 0, 0, 0, 0, One, 0, One), 1'b1);
    // endpoint on the circle, and stopping short
    send_beat(pack_pair(-3 * One, 0, 0, -One, 0, 0, 0, 0, One, -One, 2 * One), 1'b1);
    send_beat(pack_pair(-3 * One, 0, 0, -One - 1, 0, 0, 0, 0, One, -One, 2 * One), 1'b1);
    // crossing below base, rising, falling, wholly inside
    send_beat(pack_pair(-2 * One, -3 * One, 0, 2 * One, -2 * One, 0, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(-2 * One, -One, 0, 2 * One, 2 * One, 0, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(-2 * One, 2 * One, 0, 2 * One, -One, 0, 0, 0, One, 0, One), 1'b1);
    send_beat(pack_pair(-One / 4, One / 4, 0, One / 4, One / 2, 0, 0, 0, One, 0, One), 1'b1);
    // slope touching a cap corner
    send_beat(pack_pair(-3 * One, 3 * One, 0, One, -One, 0, 0, 0, One, 0, One), 1'b1);
    for (int n = 0; n < 1900; n++) begin
      if (n == 1300) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_beat(random_pair(), !(n >= 600 && n < 900));
    end
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
